/* hdl/dltq_pkg.sv */
// ----------------------------------------------------------------------------
// dltq_pkg - shared definitions for the delta-list timeout queue
// types for queue entries and the shared subtract unit, sizing constants
// ----------------------------------------------------------------------------
package dltq_pkg;

    localparam int DATA_W            = 16;
    localparam int QUEUE_DEPTH_DEF   = 16;
    localparam int MAX_RESULTS       = 16;
    localparam int RES_CNT_W         = $clog2(MAX_RESULTS + 1);

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef struct packed {
        logic [DATA_W-1:0] tag;
        logic [DATA_W-1:0] delay;
    } t_entry;

    typedef struct packed {
        logic [DATA_W-1:0] diff;
        logic              lt;
    } t_alu_res;

endpackage

/* hdl/delta_list_timeout_queue_unit.sv */
// ----------------------------------------------------------------------------
// delta_list_timeout_queue_unit - delta-encoded timeout queue
// time-ordered job queue, each entry holding its delay after the one before
// ----------------------------------------------------------------------------
// usage
//   input beat: start is sampled while busy is low; i_kind selects add or
//   tick, i_job_tag and i_timeout_seconds carry the add payload
//   result beat: o_valid is high for exactly one cycle per result, with
//   o_expired_tag, o_rejected and o_last_in_run; the receiver cannot stall
//   sequencing, n entries queued:
//     zero timeout, full queue or empty queue: result (if any) shows the
//     cycle after start, busy stays low
//     insert at position p: a walk down the list, then shift and placement
//     when it lands before the tail
//     tick: the accepting cycle fetches the head, then the expired entries
//     (at most MAX_RESULTS) go out one by one
//   the single memory read port sets the pace: the walk and the shift
//   touch one entry per cycle, all deltas going through one subtractor
//   reset: the queue is emptied (count and head pointer cleared), entry
//   contents are left as they are and never read before being written
//   storage is a circular buffer; a pop only moves the head pointer
// ----------------------------------------------------------------------------
module delta_list_timeout_queue_unit
    import dltq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_kind,
    input  logic [DATA_W-1:0] i_job_tag,
    input  logic [DATA_W-1:0] i_timeout_seconds,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_expired_tag,
    output logic              o_rejected,
    output logic              o_last_in_run
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int SW = PW + 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_SHIFT_START,
        S_SHIFT,
        S_PLACE,
        S_TICK,
        S_POP,
        S_FLUSH
    } t_state;

    // sequencer registers
    t_state              r_state,   n_state;
    logic [CW-1:0]       r_count,   n_count;
    logic [PW-1:0]       r_head,    n_head;
    logic [PW-1:0]       r_idx,     n_idx;
    logic [PW-1:0]       r_pos,     n_pos;
    logic [DATA_W-1:0]   r_t,       n_t;
    logic [DATA_W-1:0]   r_tag,     n_tag;
    logic [DATA_W-1:0]   r_cur_tag, n_cur_tag;
    logic [RES_CNT_W-1:0] r_n,      n_n;

    // result beat registers
    logic                r_valid,   n_valid;
    logic [DATA_W-1:0]   r_out_tag, n_out_tag;
    logic                r_rej,     n_rej;
    logic                r_last,    n_last;

    // memory and subtractor hookup
    logic                w_we;
    logic [PW-1:0]       w_wr_l;
    logic [PW-1:0]       w_rd_l;
    t_entry              w_wdata;
    t_entry              w_rdata;
    logic [DATA_W-1:0]   w_alu_a;
    logic [DATA_W-1:0]   w_alu_b;
    t_alu_res            w_alu;
    logic [DATA_W-1:0]   w_dec;

    // logical queue position to memory address
    function automatic logic [PW-1:0] phys(input logic [PW-1:0] base,
                                           input logic [PW-1:0] l);
        logic [SW-1:0] s;
        s = {1'b0, base} + {1'b0, l};
        if (s >= SW'(QUEUE_DEPTH)) begin
            s = s - SW'(QUEUE_DEPTH);
        end
        return s[PW-1:0];
    endfunction

    dltq_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PW          (PW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (phys(r_head, w_wr_l)),
        .i_wdata (w_wdata),
        .i_raddr (phys(r_head, w_rd_l)),
        .o_rdata (w_rdata)
    );

    dltq_alu u_alu (
        .i_a   (w_alu_a),
        .i_b   (w_alu_b),
        .o_res (w_alu)
    );

    // saturating decrement of the head delay
    assign w_dec = w_alu.lt ? '0 : w_alu.diff;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_head    = r_head;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_t       = r_t;
        n_tag     = r_tag;
        n_cur_tag = r_cur_tag;
        n_n       = r_n;
        n_valid   = 1'b0;
        n_out_tag = r_out_tag;
        n_rej     = 1'b0;
        n_last    = 1'b0;
        w_we      = 1'b0;
        w_wr_l    = '0;
        w_rd_l    = '0;
        w_wdata   = '{tag: r_tag, delay: r_t};
        w_alu_a   = r_t;
        w_alu_b   = w_rdata.delay;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_kind == KIND_ADD) begin
                        if (i_timeout_seconds == '0) begin
                            // zero timeout expires at once, even on a full queue
                            n_valid   = 1'b1;
                            n_out_tag = i_job_tag;
                            n_last    = 1'b1;
                        end else if (r_count == CW'(QUEUE_DEPTH)) begin
                            n_valid   = 1'b1;
                            n_out_tag = i_job_tag;
                            n_rej     = 1'b1;
                            n_last    = 1'b1;
                        end else if (r_count == '0) begin
                            w_we    = 1'b1;
                            w_wr_l  = '0;
                            w_wdata = '{tag: i_job_tag, delay: i_timeout_seconds};
                            n_count = r_count + CW'(1);
                        end else begin
                            n_t     = i_timeout_seconds;
                            n_tag   = i_job_tag;
                            n_idx   = '0;
                            w_rd_l  = '0;
                            n_state = S_WALK;
                        end
                    end else if (r_count != '0) begin
                        w_rd_l  = '0;
                        n_state = S_TICK;
                    end
                end
            end

            S_WALK: begin
                // entry r_idx is in the read register, next one fetched ahead
                w_alu_a = r_t;
                w_alu_b = w_rdata.delay;
                w_rd_l  = r_idx + PW'(1);
                if (w_alu.lt) begin
                    n_pos   = r_idx;
                    n_state = S_SHIFT_START;
                end else begin
                    n_t = w_alu.diff;
                    if (CW'(r_idx) + CW'(1) == r_count) begin
                        // append behind the tail
                        w_we    = 1'b1;
                        w_wr_l  = r_count[PW-1:0];
                        w_wdata = '{tag: r_tag, delay: w_alu.diff};
                        n_count = r_count + CW'(1);
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + PW'(1);
                    end
                end
            end

            S_SHIFT_START: begin
                w_rd_l  = PW'(r_count - CW'(1));
                n_idx   = PW'(r_count - CW'(1));
                n_state = S_SHIFT;
            end

            S_SHIFT: begin
                // move entry r_idx up one place, fetch the one below
                w_alu_a = w_rdata.delay;
                w_alu_b = r_t;
                w_we    = 1'b1;
                w_wr_l  = r_idx + PW'(1);
                w_wdata = '{tag: w_rdata.tag,
                            delay: (r_idx == r_pos) ? w_alu.diff : w_rdata.delay};
                w_rd_l  = (r_idx == '0) ? '0 : r_idx - PW'(1);
                if (r_idx == r_pos) begin
                    n_state = S_PLACE;
                end else begin
                    n_idx = r_idx - PW'(1);
                end
            end

            S_PLACE: begin
                w_we    = 1'b1;
                w_wr_l  = r_pos;
                w_wdata = '{tag: r_tag, delay: r_t};
                n_count = r_count + CW'(1);
                n_state = S_IDLE;
            end

            S_TICK: begin
                w_alu_a = w_rdata.delay;
                w_alu_b = DATA_W'(1);
                if (w_dec != '0) begin
                    w_we    = 1'b1;
                    w_wr_l  = '0;
                    w_wdata = '{tag: w_rdata.tag, delay: w_dec};
                    n_state = S_IDLE;
                end else begin
                    n_cur_tag = w_rdata.tag;
                    n_head    = phys(r_head, PW'(1));
                    n_count   = r_count - CW'(1);
                    n_n       = RES_CNT_W'(1);
                    if (r_count == CW'(1) || MAX_RESULTS == 1) begin
                        n_valid   = 1'b1;
                        n_out_tag = w_rdata.tag;
                        n_last    = 1'b1;
                        n_state   = S_IDLE;
                    end else begin
                        w_rd_l  = PW'(1);
                        n_state = S_POP;
                    end
                end
            end

            S_POP: begin
                // pending tag goes out once we know whether more follow
                n_valid   = 1'b1;
                n_out_tag = r_cur_tag;
                if (w_rdata.delay != '0) begin
                    n_last  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_cur_tag = w_rdata.tag;
                    n_head    = phys(r_head, PW'(1));
                    n_count   = r_count - CW'(1);
                    n_n       = r_n + RES_CNT_W'(1);
                    if (r_count == CW'(1) ||
                        r_n + RES_CNT_W'(1) == RES_CNT_W'(MAX_RESULTS)) begin
                        n_state = S_FLUSH;
                    end else begin
                        w_rd_l = PW'(1);
                    end
                end
            end

            S_FLUSH: begin
                n_valid   = 1'b1;
                n_out_tag = r_cur_tag;
                n_last    = 1'b1;
                n_state   = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_head  <= '0;
            r_n     <= '0;
            r_valid <= 1'b0;
            r_rej   <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
            r_n     <= n_n;
            r_valid <= n_valid;
            r_rej   <= n_rej;
            r_last  <= n_last;
        end
        r_idx     <= n_idx;
        r_pos     <= n_pos;
        r_t       <= n_t;
        r_tag     <= n_tag;
        r_cur_tag <= n_cur_tag;
        r_out_tag <= n_out_tag;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_expired_tag = r_out_tag;
    assign o_rejected    = r_rej;
    assign o_last_in_run = r_last;

`ifndef ASSERT_OFF
    // fill level stays within the queue
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    // one insert or one pop per cycle at most
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 (r_count == $past(r_count) || r_count == $past(r_count) + CW'(1) ||
             r_count == $past(r_count) - CW'(1)))
        else $error("entry count moved by more than one");

    // a run that is not finished keeps the block busy
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_in_run) |-> busy)
        else $error("partial expiry run while idle");

    // a rejection is always a single-beat run
    a_rej_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rejected) |-> o_last_in_run)
        else $error("rejection not marked last");

    // a nonzero add on a full queue is rejected in the next cycle
    a_full_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind == KIND_ADD && i_timeout_seconds != '0 &&
         r_count == CW'(QUEUE_DEPTH)) |=> (o_valid && o_rejected))
        else $error("add on full queue not rejected");
`endif

endmodule

/* hdl/dltq_alu.sv */
// ----------------------------------------------------------------------------
// dltq_alu - shared subtract and compare unit
// gives a - b and the borrow (a < b) for the sequencer
// ----------------------------------------------------------------------------
module dltq_alu
    import dltq_pkg::*;
(
    input  logic [DATA_W-1:0] i_a,
    input  logic [DATA_W-1:0] i_b,
    output t_alu_res          o_res
);

    logic [DATA_W:0] w_sub;

    assign w_sub      = {1'b0, i_a} - {1'b0, i_b};
    assign o_res.diff = w_sub[DATA_W-1:0];
    assign o_res.lt   = w_sub[DATA_W];

endmodule

/* hdl/dltq_store.sv */
// ----------------------------------------------------------------------------
// dltq_store - entry memory of the timeout queue
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module dltq_store
    import dltq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int PW          = $clog2(QUEUE_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [PW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [PW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [QUEUE_DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for the delta-list timeout queue
// a scoreboard class keeps its own delta list of pending jobs and predicts
// every expiry, rejection and zero-timeout result; plain tasks drive beats
// ----------------------------------------------------------------------------
module tb;
    import dltq_pkg::*;

    localparam int Q_DEPTH      = QUEUE_DEPTH_DEF;
    localparam int RANDOM_BEATS = 480;
    localparam int TAIL_CYCLES  = 48;

    // one expected result beat
    typedef struct packed {
        logic [DATA_W-1:0] tag;
        logic              rejected;
        logic              last;
    } t_expiry;

    // ------------------------------------------------------------------------
    // scoreboard: private delta list plus the queue of results still owed
    // ------------------------------------------------------------------------
    class expiry_scoreboard;
        logic [DATA_W-1:0] job_tag   [Q_DEPTH];
        logic [DATA_W-1:0] job_delta [Q_DEPTH];
        int                jobs_held;
        t_expiry           owed[$];
        int                errors;
        int                beats;
        int                results;
        int                rejections;
        int                instant;
        int                longest_run;

        function new();
            jobs_held   = 0;
            errors      = 0;
            beats       = 0;
            results     = 0;
            rejections  = 0;
            instant     = 0;
            longest_run = 0;
        endfunction

        // append one expected result beat
        function void owe(logic [DATA_W-1:0] tag, logic rej, logic last);
            t_expiry e;
            e.tag      = tag;
            e.rejected = rej;
            e.last     = last;
            owed.insert(owed.size(), e);
        endfunction

        // accepted input beat: update the list and queue what it causes
        function void note_beat(logic kind, logic [DATA_W-1:0] tag,
                                logic [DATA_W-1:0] secs);
            int                pos;
            int                i;
            int                run;
            logic [DATA_W-1:0] rest;
            t_expiry           e;
            beats++;
            if (kind == KIND_ADD) begin
                if (secs == '0) begin
                    owe(tag, 1'b0, 1'b1);
                    instant++;
                end else if (jobs_held >= Q_DEPTH) begin
                    owe(tag, 1'b1, 1'b1);
                end else begin
                    // walk past every job due no later than this one
                    rest = secs;
                    pos  = 0;
                    while (pos < jobs_held && rest >= job_delta[pos]) begin
                        rest = rest - job_delta[pos];
                        pos++;
                    end
                    if (pos < jobs_held)
                        job_delta[pos] = job_delta[pos] - rest;
                    for (i = jobs_held; i > pos; i--) begin
                        job_tag[i]   = job_tag[i-1];
                        job_delta[i] = job_delta[i-1];
                    end
                    job_tag[pos]   = tag;
                    job_delta[pos] = rest;
                    jobs_held++;
                end
            end else if (jobs_held != 0) begin
                if (job_delta[0] != '0)
                    job_delta[0] = job_delta[0] - 1'b1;
                run = 0;
                while (jobs_held != 0 && job_delta[0] == '0 && run < MAX_RESULTS) begin
                    owe(job_tag[0], 1'b0, 1'b0);
                    for (i = 1; i < jobs_held; i++) begin
                        job_tag[i-1]   = job_tag[i];
                        job_delta[i-1] = job_delta[i];
                    end
                    jobs_held--;
                    run++;
                end
                if (run > 0) begin
                    e      = owed[owed.size()-1];
                    e.last = 1'b1;
                    owed[owed.size()-1] = e;
                end
                if (run > longest_run)
                    longest_run = run;
            end
        endfunction

        function void report(string what, int unsigned exp_v, int unsigned act_v);
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, what,
                     exp_v, act_v);
        endfunction

        // result beat from the block, compared with the oldest one owed
        function void check_result(logic [DATA_W-1:0] tag, logic rej, logic last);
            t_expiry e;
            results++;
            if (rej)
                rejections++;
            if (owed.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none %s %h rej %0b last %0b",
                         $time, "actual tag", tag, rej, last);
                return;
            end
            e = owed[0];
            owed.delete(0);
            if (tag !== e.tag)
                report("expired_tag", e.tag, tag);
            if (rej !== e.rejected)
                report("rejected", e.rejected, rej);
            if (last !== e.last)
                report("last_in_run", e.last, last);
        endfunction

        function int outstanding();
            return owed.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block ports; the driven inputs are known from time zero
    // ------------------------------------------------------------------------
    logic              i_clk             = 1'b0;
    logic              i_rst_n           = 1'b0;
    logic              start             = 1'b0;
    logic              i_kind            = KIND_ADD;
    logic [DATA_W-1:0] i_job_tag         = '0;
    logic [DATA_W-1:0] i_timeout_seconds = '0;
    logic              busy;
    logic              o_valid;
    logic [DATA_W-1:0] o_expired_tag;
    logic              o_rejected;
    logic              o_last_in_run;

    expiry_scoreboard sb;
    int               idle_pct = 34;   // chance in a hundred of an idle sender cycle

    always #6 i_clk = ~i_clk;

    delta_list_timeout_queue_unit #(
        .QUEUE_DEPTH (Q_DEPTH)
    ) u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_kind            (i_kind),
        .i_job_tag         (i_job_tag),
        .i_timeout_seconds (i_timeout_seconds),
        .o_valid           (o_valid),
        .o_expired_tag     (o_expired_tag),
        .o_rejected        (o_rejected),
        .o_last_in_run     (o_last_in_run)
    );

    // ------------------------------------------------------------------------
    // monitor: one block so a result is always checked before a beat taken
    // at the same edge is noted; a result can never belong to that beat
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid)
                sb.check_result(o_expired_tag, o_rejected, o_last_in_run);
            if (start && !busy)
                sb.note_beat(i_kind, i_job_tag, i_timeout_seconds);
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // present one beat, after idle cycles drawn one by one, and return at the
    // edge that takes it; start stays high if the next beat follows at once
    task automatic send_beat(input logic kind, input logic [DATA_W-1:0] tag,
                             input logic [DATA_W-1:0] secs);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start             <= 1'b1;
        i_kind            <= kind;
        i_job_tag         <= tag;
        i_timeout_seconds <= secs;
        do @(posedge i_clk); while (busy);
    endtask

    // hold the sender off until every owed result is back and the block idles
    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (busy || sb.outstanding() != 0);
    endtask

    // mostly short timeouts so jobs really expire during the run, a few
    // zeros for the instant path and the odd one from the whole range
    function automatic logic [DATA_W-1:0] pick_timeout();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        else if (r < 70)
            return DATA_W'($urandom_range(1, 6));
        else if (r < 97)
            return DATA_W'($urandom_range(7, 60));
        else
            return DATA_W'($urandom_range(1, 65535));
    endfunction

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        int sent;
        int k;
        int burst;
        int next_pct;
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: tick with nothing queued
        send_beat(KIND_TICK, '0, '0);
        // zero timeout on an empty queue, all-ones tag
        send_beat(KIND_ADD, 16'hFFFF, '0);
        // fill to the brim with jobs all due together; tags sweep every bit
        // and equal times must keep arrival order
        for (k = 0; k < Q_DEPTH; k++)
            send_beat(KIND_ADD, DATA_W'(k * 16'h1111), 16'd2);
        // full queue: rejected with the longest timeout, instant still served
        send_beat(KIND_ADD, 16'h8001, 16'hFFFF);
        send_beat(KIND_ADD, 16'h7FFE, '0);
        // one tick of countdown, then the whole queue expires in one burst
        send_beat(KIND_TICK, 16'h5A5A, 16'hA5A5);
        send_beat(KIND_TICK, '0, '0);
        settle();

        // random: bursts of adds then runs of ticks, so the list fills,
        // overflows, reorders and drains over and over
        sent = 0;
        while (sent < RANDOM_BEATS) begin
            next_pct = (sent < RANDOM_BEATS / 3)     ? 34 :
                       (sent < 2 * RANDOM_BEATS / 3) ? 52 : 0;
            if (next_pct != idle_pct) begin
                settle();
                idle_pct = next_pct;
            end
            burst = $urandom_range(1, 18);
            for (k = 0; k < burst; k++) begin
                send_beat(KIND_ADD, DATA_W'($urandom), pick_timeout());
                sent++;
            end
            burst = $urandom_range(1, 16);
            for (k = 0; k < burst; k++) begin
                // payload of a tick is ignored but still toggled
                send_beat(KIND_TICK, DATA_W'($urandom), DATA_W'($urandom));
                sent++;
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("tb: %0d beats in, %0d results out, %0d rejections, %0d instant expiries",
                 sb.beats, sb.results, sb.rejections, sb.instant);
        $display("tb: longest expiry burst %0d, %0d jobs still queued at the end",
                 sb.longest_run, sb.jobs_held);
        if (sb.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule
